// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros used by the checker of this project
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every edge outside reset.
`define WCTM_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("wctm assertion failed");

// Property checked at every edge, reset included.
`define WCTM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("wctm assertion failed");

`endif

// ----- rtl/wctm_pkg.sv -----
// ----------------------------------------------------------------------------
// wctm_pkg
// Types and constants of the wall column texel mapper.
// ----------------------------------------------------------------------------
package wctm_pkg;

  localparam int MAX_TEX_DIM    = 1024;
  localparam int MAX_SCREEN_DIM = 4096;
  localparam int PITCH_MAX      = 8192;
  localparam int BPP_MAX        = 4;

  localparam int HDIV_STAGES = 20;  // quotient bits of the height divider
  localparam int RDIV_STAGES = 10;  // quotient bits of the row divider

  typedef enum logic [2:0] {
    REG_SCREEN_HEIGHT = 3'd0,
    REG_TEX_WIDTH     = 3'd1,
    REG_TEX_HEIGHT    = 3'd2,
    REG_ROW_PITCH     = 3'd3,
    REG_BYTES_PER_PIX = 3'd4
  } reg_idx_t;

  localparam logic [2:0] FACE_NORTH = 3'd0;
  localparam logic [2:0] FACE_SOUTH = 3'd1;
  localparam logic [2:0] FACE_EAST  = 3'd2;
  localparam logic [2:0] FACE_WEST  = 3'd3;
  localparam logic [2:0] TEX_DOOR   = 3'd4;

  // Saturated configuration as the datapath uses it
  typedef struct packed {
    logic [11:0] sh;
    logic [10:0] tw;
    logic [10:0] th;
    logic [13:0] pitch;
    logic [2:0]  bpp;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  face;
    logic        door;
    logic [15:0] dist_q8;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [11:0] col;
    logic [19:0] wrow;
  } in_t;

  typedef struct packed {
    logic        pv;
    logic [2:0]  tid;
    logic [9:0]  tcol;
    logic [11:0] col;
    logic [19:0] wrow;
    logic [30:0] rprod;
    logic [15:0] dist_q8;
  } item_t;

  typedef struct packed {
    logic        pv;
    logic [2:0]  tid;
    logic [9:0]  tcol;
    logic [11:0] col;
    logic [30:0] rprod;
    logic [19:0] wh;
    logic [20:0] srow;
    logic        onscr;
    logic        last;
  } mid_t;

  typedef struct packed {
    logic        pv;
    logic [2:0]  tid;
    logic [9:0]  tcol;
    logic [9:0]  trow;
    logic [23:0] offs;
    logic [11:0] col;
    logic [20:0] srow;
    logic        onscr;
    logic        last;
    logic [19:0] wh;
  } res_t;

endpackage

// ----- rtl/wctm_front.sv -----
// ----------------------------------------------------------------------------
// wctm_front
// Input register, texture select and the two products of the front end.
// ----------------------------------------------------------------------------
module wctm_front import wctm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  in_t   in_d,
  input  cfg_t  cfg,
  output logic  out_vld,
  output item_t out_d
);

  logic        v0;
  in_t         r0;
  logic        v1;
  logic        pv1;
  logic [2:0]  tid1;
  logic [26:0] fprod;
  logic [11:0] col1;
  logic [19:0] wrow1;
  logic [30:0] rprod1;
  logic [15:0] dist1;

  logic        pv0;
  logic [2:0]  tid0;
  logic [15:0] frac;
  logic [10:0] tcol_raw;
  logic [9:0]  tw_m1;
  logic [9:0]  tcol;

  always_comb begin
    pv0      = r0.door || (r0.face <= FACE_WEST);
    tid0     = r0.door ? TEX_DOOR : r0.face;
    frac     = (r0.face == FACE_NORTH || r0.face == FACE_SOUTH) ? r0.fx : r0.fy;
    tcol_raw = fprod[26:16];
    tw_m1    = 10'(cfg.tw - 11'd1);
    tcol     = (tcol_raw > {1'b0, tw_m1}) ? tw_m1 : tcol_raw[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0      <= 1'b0;
      v1      <= 1'b0;
      out_vld <= 1'b0;
    end else if (en) begin
      v0      <= in_vld;
      v1      <= v0;
      out_vld <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0     <= in_d;
      pv1    <= pv0;
      tid1   <= tid0;
      fprod  <= 27'(frac) * 27'(cfg.tw);
      col1   <= r0.col;
      wrow1  <= r0.wrow;
      rprod1 <= 31'(r0.wrow) * 31'(cfg.th);
      dist1  <= (r0.dist_q8 == 16'd0) ? 16'd1 : r0.dist_q8;

      out_d.pv      <= pv1;
      out_d.tid     <= tid1;
      out_d.tcol    <= tcol;
      out_d.col     <= col1;
      out_d.wrow    <= wrow1;
      out_d.rprod   <= rprod1;
      out_d.dist_q8 <= dist1;
    end
  end

endmodule

// ----- rtl/wctm_hdiv.sv -----
// ----------------------------------------------------------------------------
// wctm_hdiv
// Pipelined restoring divider for the wall height, then screen row and flags.
// ----------------------------------------------------------------------------
module wctm_hdiv import wctm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_vld,
  input  item_t in_d,
  input  cfg_t  cfg,
  output logic  out_vld,
  output mid_t  out_d
);

  logic [19:0] num;
  logic        v_q   [1:HDIV_STAGES];
  logic [15:0] rem_q [1:HDIV_STAGES];
  logic [19:0] quo_q [1:HDIV_STAGES];
  item_t       it_q  [1:HDIV_STAGES];

  assign num = {cfg.sh, 8'd0};

  for (genvar k = 0; k < HDIV_STAGES; k++) begin : g_stg
    logic        vin;
    logic [15:0] rin;
    logic [19:0] qin;
    item_t       iin;
    logic [16:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vin = in_vld;
      assign rin = '0;
      assign qin = '0;
      assign iin = in_d;
    end else begin : g_next
      assign vin = v_q[k];
      assign rin = rem_q[k];
      assign qin = quo_q[k];
      assign iin = it_q[k];
    end

    assign trial = {rin, num[HDIV_STAGES-1-k]};
    assign ge    = trial >= {1'b0, iin.dist_q8};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? 16'(trial - {1'b0, iin.dist_q8}) : trial[15:0];
        quo_q[k+1] <= {qin[18:0], ge};
        it_q[k+1]  <= iin;
      end
    end
  end

  logic [19:0]        wh;
  item_t              itm;
  logic signed [21:0] diff;
  logic signed [21:0] adj;
  logic signed [21:0] srow_w;

  always_comb begin
    wh     = quo_q[HDIV_STAGES];
    itm    = it_q[HDIV_STAGES];
    diff   = $signed({10'd0, cfg.sh}) - $signed({2'd0, wh});
    // halve toward zero
    adj    = diff + $signed({21'd0, diff[21]});
    srow_w = $signed({2'd0, itm.wrow}) + (adj >>> 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_q[HDIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.pv    <= itm.pv;
      out_d.tid   <= itm.tid;
      out_d.tcol  <= itm.tcol;
      out_d.col   <= itm.col;
      out_d.rprod <= itm.rprod;
      out_d.wh    <= wh;
      out_d.srow  <= (srow_w > 22'sd1048575) ? 21'h0FFFFF : srow_w[20:0];
      out_d.onscr <= !srow_w[21] && (srow_w < $signed({10'd0, cfg.sh}));
      out_d.last  <= itm.wrow >= wh;
    end
  end

endmodule

// ----- rtl/wctm_rdiv.sv -----
// ----------------------------------------------------------------------------
// wctm_rdiv
// Pipelined divider for the texture row, then row clamp and texel offset.
// ----------------------------------------------------------------------------
module wctm_rdiv import wctm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_vld,
  input  mid_t in_d,
  input  cfg_t cfg,
  output logic out_vld,
  output res_t out_d
);

  logic        v_q   [1:RDIV_STAGES];
  logic [20:0] rem_q [1:RDIV_STAGES];
  logic [9:0]  quo_q [1:RDIV_STAGES];
  mid_t        it_q  [1:RDIV_STAGES];

  // Row below the wall height keeps the quotient under 1024, so the top
  // bits of the product start as the first partial remainder.
  for (genvar k = 0; k < RDIV_STAGES; k++) begin : g_stg
    logic        vin;
    logic [20:0] rin;
    logic [9:0]  qin;
    mid_t        iin;
    logic [21:0] trial;
    logic        ge;

    if (k == 0) begin : g_first
      assign vin = in_vld;
      assign rin = in_d.rprod[30:10];
      assign qin = '0;
      assign iin = in_d;
    end else begin : g_next
      assign vin = v_q[k];
      assign rin = rem_q[k];
      assign qin = quo_q[k];
      assign iin = it_q[k];
    end

    assign trial = {rin, iin.rprod[RDIV_STAGES-1-k]};
    assign ge    = trial >= {2'd0, iin.wh};

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (en) begin
        v_q[k+1] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[k+1] <= ge ? 21'(trial - {2'd0, iin.wh}) : trial[20:0];
        quo_q[k+1] <= {qin[8:0], ge};
        it_q[k+1]  <= iin;
      end
    end
  end

  mid_t        itm;
  logic [9:0]  th_m1;
  logic [9:0]  trow;
  logic [23:0] offs;

  always_comb begin
    itm   = it_q[RDIV_STAGES];
    th_m1 = 10'(cfg.th - 11'd1);
    if (itm.wh == 20'd0) begin
      trow = '0;
    end else if (itm.last) begin
      trow = th_m1;
    end else begin
      trow = quo_q[RDIV_STAGES];
    end
    offs = 24'(trow) * 24'(cfg.pitch) + 24'(itm.tcol) * 24'(cfg.bpp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= v_q[RDIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_d.pv    <= itm.pv;
      out_d.tid   <= itm.pv ? itm.tid : 3'd0;
      out_d.tcol  <= itm.pv ? itm.tcol : 10'd0;
      out_d.trow  <= itm.pv ? trow : 10'd0;
      out_d.offs  <= itm.pv ? offs : 24'd0;
      out_d.col   <= itm.col;
      out_d.srow  <= itm.pv ? itm.srow : 21'd0;
      out_d.onscr <= itm.pv && itm.onscr;
      out_d.last  <= itm.pv && itm.last;
      out_d.wh    <= itm.wh;
    end
  end

endmodule

// ----- rtl/wctm_out.sv -----
// ----------------------------------------------------------------------------
// wctm_out
// Output register with a skid entry; frees the pipeline from downstream ready.
// ----------------------------------------------------------------------------
module wctm_out import wctm_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_vld,
  input  res_t in_d,
  input  logic m_ready,
  output logic en,
  output logic m_valid,
  output res_t m_d
);

  logic skid_v;
  res_t skid_d;

  assign en = !skid_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      skid_v  <= 1'b0;
    end else if (skid_v) begin
      if (m_ready) begin
        skid_v <= 1'b0;
      end
    end else if (!m_valid || m_ready) begin
      m_valid <= in_vld;
    end else if (in_vld) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v) begin
      if (m_ready) begin
        m_d <= skid_d;
      end
    end else if (!m_valid || m_ready) begin
      m_d <= in_d;
    end else begin
      skid_d <= in_d;
    end
  end

endmodule

// ----- rtl/wall_column_texel_mapper.sv -----
// ----------------------------------------------------------------------------
// wall_column_texel_mapper
// Maps each pixel of a ray-cast wall column to its texture and texel offset.
//
//   channel  dir  handshake            payload
//   s_*      in   s_tvalid/s_tready    tdata 80b, tuser face+door
//   m_*      out  m_tvalid/m_tready    tdata 104b, tuser flags+id, tlast
//   cfg_*    in   cfg_valid/cfg_ready  cfg_index 3b, cfg_data 14b
//
// One pixel per cycle while the skid entry is empty; 36 register stages (3 front,
// 21 height divider, 11 row divider, 1 output), set by the one-bit-per-stage
// dividers.
// Reset clears all valid bits and loads the register defaults.
// A downstream stall fills the skid entry, then s_tready drops; nothing is
// lost or repeated. cfg_ready is always high.
// ----------------------------------------------------------------------------
module wall_column_texel_mapper import wctm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // dist_q8[15:0], hit_x_frac[31:16], hit_y_frac[47:32], column[59:48],
  // wall_row[79:60]
  input  logic [79:0]  s_tdata,
  // face[2:0], door[3]
  input  logic [3:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tex_col[9:0], tex_row[19:10], texel_offset[43:20], screen_col[55:44],
  // screen_row[76:56], slice_height[96:77], zero[103:97]
  output logic [103:0] m_tdata,
  // pixel_valid[0], texture_id[3:1], on_screen[4]
  output logic [4:0]   m_tuser,
  output logic         m_tlast,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [13:0]  cfg_data
);

  logic [11:0] screen_height;
  logic [10:0] tex_width;
  logic [10:0] tex_height;
  logic [13:0] row_pitch;
  logic [2:0]  bytes_per_pixel;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_height   <= 12'd720;
      tex_width       <= 11'd64;
      tex_height      <= 11'd64;
      row_pitch       <= 14'd256;
      bytes_per_pixel <= 3'd4;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SCREEN_HEIGHT: screen_height   <= cfg_data[11:0];
        REG_TEX_WIDTH:     tex_width       <= cfg_data[10:0];
        REG_TEX_HEIGHT:    tex_height      <= cfg_data[10:0];
        REG_ROW_PITCH:     row_pitch       <= cfg_data;
        REG_BYTES_PER_PIX: bytes_per_pixel <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  cfg_t cfg;

  always_comb begin
    cfg.sh    = (screen_height == 12'd0) ? 12'd1 : screen_height;
    cfg.tw    = (tex_width == 11'd0) ? 11'd1 :
                (tex_width > 11'(MAX_TEX_DIM)) ? 11'(MAX_TEX_DIM) : tex_width;
    cfg.th    = (tex_height == 11'd0) ? 11'd1 :
                (tex_height > 11'(MAX_TEX_DIM)) ? 11'(MAX_TEX_DIM) : tex_height;
    cfg.pitch = (row_pitch > 14'(PITCH_MAX)) ? 14'(PITCH_MAX) : row_pitch;
    cfg.bpp   = (bytes_per_pixel > 3'(BPP_MAX)) ? 3'(BPP_MAX) : bytes_per_pixel;
  end

  in_t in_d;

  always_comb begin
    in_d.face    = s_tuser[2:0];
    in_d.door    = s_tuser[3];
    in_d.dist_q8 = s_tdata[15:0];
    in_d.fx      = s_tdata[31:16];
    in_d.fy      = s_tdata[47:32];
    in_d.col     = s_tdata[59:48];
    in_d.wrow    = s_tdata[79:60];
  end

  logic  en;
  logic  f_vld;
  item_t f_d;
  logic  h_vld;
  mid_t  h_d;
  logic  r_vld;
  res_t  r_d;
  res_t  o_d;

  assign s_tready = en;

  wctm_front u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_tvalid),
    .in_d    (in_d),
    .cfg     (cfg),
    .out_vld (f_vld),
    .out_d   (f_d)
  );

  wctm_hdiv u_hdiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (f_vld),
    .in_d    (f_d),
    .cfg     (cfg),
    .out_vld (h_vld),
    .out_d   (h_d)
  );

  wctm_rdiv u_rdiv (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (h_vld),
    .in_d    (h_d),
    .cfg     (cfg),
    .out_vld (r_vld),
    .out_d   (r_d)
  );

  wctm_out u_out (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (r_vld),
    .in_d    (r_d),
    .m_ready (m_tready),
    .en      (en),
    .m_valid (m_tvalid),
    .m_d     (o_d)
  );

  assign m_tdata = {7'd0, o_d.wh, o_d.srow, o_d.col, o_d.offs, o_d.trow, o_d.tcol};
  assign m_tuser = {o_d.onscr, o_d.tid, o_d.pv};
  assign m_tlast = o_d.last;

endmodule

// ----- rtl/wctm_checker.sv -----
// ----------------------------------------------------------------------------
// wctm_checker
// Port-level checks of the wall column texel mapper, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wctm_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tvalid,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [103:0] m_tdata,
  input logic [4:0]   m_tuser,
  input logic         m_tlast
);

  // a stalled result holds
  `WCTM_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // no texture: all texture fields, screen row and flags are zero
  `WCTM_ASSERT(a_no_tex_zero, clk, rst, m_tvalid && !m_tuser[0] |-> m_tdata[43:0] == 44'd0 && m_tdata[76:56] == 21'd0 && m_tuser[4:1] == 4'd0 && !m_tlast)

  // on screen means a non-negative screen row
  `WCTM_ASSERT(a_onscr_sign, clk, rst, m_tvalid && m_tuser[4] |-> !m_tdata[76])

  // the input holds off only behind a waiting result
  `WCTM_ASSERT(a_in_stall, clk, rst, s_tvalid && !s_tready |-> m_tvalid)

  // reset empties the output
  `WCTM_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !m_tvalid)

endmodule

bind wall_column_texel_mapper wctm_checker u_wctm_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Wall column texel mapper testbench
// Drives pixels of wall columns through the stream input, predicts each
// result from its own model of the projection and texture mapping, and
// checks every output transfer in order. Registers are rewritten between
// phases while the block is idle, the extremes among them.
// ----------------------------------------------------------------------------
module testbench;
  import wctm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    bit        pv;
    bit [2:0]  tid;
    bit [9:0]  tcol;
    bit [9:0]  trow;
    bit [23:0] offs;
    bit [11:0] col;
    bit [20:0] srow;
    bit        onscr;
    bit        last;
    bit [19:0] wh;
  } texel_t;

  class texel_scoreboard;
    bit [11:0] screen_h;
    bit [10:0] tex_w;
    bit [10:0] tex_h;
    bit [13:0] pitch;
    bit [2:0]  bpp;
    texel_t    pending[$];
    int        errors;

    function void set_reg(reg_idx_t idx, bit [13:0] v);
      case (idx)
        REG_SCREEN_HEIGHT: screen_h = v[11:0];
        REG_TEX_WIDTH:     tex_w = v[10:0];
        REG_TEX_HEIGHT:    tex_h = v[10:0];
        REG_ROW_PITCH:     pitch = v;
        REG_BYTES_PER_PIX: bpp = v[2:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(bit [2:0] face, bit door, bit [15:0] dist_q8, bit [15:0] fx,
                             bit [15:0] fy, bit [11:0] col, bit [19:0] wrow);
      longint sh, tw, th, pt, bp, d, wh, fr, tc, tr, sr;
      texel_t e;
      sh = screen_h == 0 ? 1 : (screen_h > MAX_SCREEN_DIM - 1 ? MAX_SCREEN_DIM - 1 : screen_h);
      tw = tex_w == 0 ? 1 : (tex_w > MAX_TEX_DIM ? MAX_TEX_DIM : tex_w);
      th = tex_h == 0 ? 1 : (tex_h > MAX_TEX_DIM ? MAX_TEX_DIM : tex_h);
      pt = pitch > PITCH_MAX ? PITCH_MAX : pitch;
      bp = bpp > BPP_MAX ? BPP_MAX : bpp;
      d = dist_q8 == 0 ? 1 : dist_q8;
      wh = (sh * 256) / d;
      if (wh > 20'hFFFFF) wh = 20'hFFFFF;
      e = '{default: 0};
      e.col = col;
      e.wh = 20'(wh);
      e.pv = door || face <= FACE_WEST;
      if (e.pv) begin
        e.tid = door ? TEX_DOOR : face;
        fr = (face == FACE_NORTH || face == FACE_SOUTH) ? fx : fy;
        tc = (fr * tw) >> 16;
        if (tc > tw - 1) tc = tw - 1;
        tr = wh == 0 ? 0 : (longint'(wrow) * th) / wh;
        if (tr > th - 1) tr = th - 1;
        e.tcol = 10'(tc);
        e.trow = 10'(tr);
        e.offs = 24'(tr * pt + tc * bp);
        sr = longint'(wrow) + (sh - wh) / 2;
        if (sr > 1048575) sr = 1048575;
        if (sr < -1048576) sr = -1048576;
        e.srow = 21'(sr);
        e.onscr = sr >= 0 && sr < sh;
        e.last = wrow >= wh;
      end
      pending.push_back(e);
    endfunction

    function void check_pixel(texel_t a);
      texel_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result pv=%0d col=%0d", $time, a.pv, a.col);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a != e) begin
        $display("%0t: mismatch exp pv=%0d id=%0d tc=%0d tr=%0d off=%0d col=%0d sr=%0d os=%0d l=%0d wh=%0d",
                 $time, e.pv, e.tid, e.tcol, e.trow, e.offs, e.col, e.srow, e.onscr, e.last, e.wh);
        $display("%0t:          got pv=%0d id=%0d tc=%0d tr=%0d off=%0d col=%0d sr=%0d os=%0d l=%0d wh=%0d",
                 $time, a.pv, a.tid, a.tcol, a.trow, a.offs, a.col, a.srow, a.onscr, a.last, a.wh);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 0;
  logic         rst = 1;
  logic         s_tvalid = 0;
  logic         s_tready;
  logic [79:0]  s_tdata = '0;
  logic [3:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 0;
  logic [103:0] m_tdata;
  logic [4:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_valid = 0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = '0;
  logic [13:0]  cfg_data = '0;

  texel_scoreboard board = new();
  bit  hold_off = 0;
  bit  sink_random = 1;

  wall_column_texel_mapper dut (.*);

  always #4 clk = ~clk;

  // output side: random stall per transfer, plus a long hold-off on request
  initial begin
    int  gap;
    texel_t a;
    @(posedge clk iff !rst);
    forever begin
      gap = sink_random ? $urandom_range(0, 17) : 0;
      if (gap != 0 || hold_off) begin
        m_tready <= 0;
        repeat (gap) @(posedge clk);
        while (hold_off) @(posedge clk);
      end
      m_tready <= 1;
      @(posedge clk iff m_tvalid);
      a.tcol = m_tdata[9:0];
      a.trow = m_tdata[19:10];
      a.offs = m_tdata[43:20];
      a.col = m_tdata[55:44];
      a.srow = m_tdata[76:56];
      a.wh = m_tdata[96:77];
      a.pv = m_tuser[0];
      a.tid = m_tuser[3:1];
      a.onscr = m_tuser[4];
      a.last = m_tlast;
      board.check_pixel(a);
      if (m_tdata[103:97] != 0) begin
        $display("%0t: pad bits exp 0 got %h", $time, m_tdata[103:97]);
        board.errors++;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, bit [13:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    board.set_reg(idx, v);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_pixel(bit [2:0] face, bit door, bit [15:0] dist_q8, bit [15:0] fx,
                            bit [15:0] fy, bit [11:0] col, bit [19:0] wrow, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= {wrow, col, fy, fx, dist_q8};
    s_tuser <= {door, face};
    @(posedge clk iff s_tready);
    board.note_pixel(face, door, dist_q8, fx, fy, col, wrow);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // random pixel; any face code, sometimes a door, wall_row near the projected height
  task automatic random_pixel(bit no_gap);
    bit [15:0] d;
    bit [19:0] r;
    int        sel;
    sel = $urandom_range(0, 9);
    d = sel == 0 ? 16'($urandom_range(0, 3)) :
        (sel == 1 ? 16'($urandom()) : 16'($urandom_range(64, 4096)));
    if ($urandom_range(0, 3) == 0) r = 20'($urandom());
    else r = 20'($urandom_range(0, 2000));
    send_pixel(3'($urandom_range(0, 7)), $urandom_range(0, 5) == 0, d, 16'($urandom()),
               16'($urandom()), 12'($urandom()), r, no_gap);
  endtask

  initial begin
    bit [13:0] sets[6][5];
    sets = '{'{720, 64, 64, 256, 4}, '{1, 1, 1, 1, 1}, '{4095, 1024, 1024, 8192, 4},
             '{0, 0, 0, 0, 0}, '{16383, 2047, 2047, 16383, 7}, '{480, 100, 37, 400, 3}};
    board.set_reg(REG_SCREEN_HEIGHT, 720);
    board.set_reg(REG_TEX_WIDTH, 64);
    board.set_reg(REG_TEX_HEIGHT, 64);
    board.set_reg(REG_ROW_PITCH, 256);
    board.set_reg(REG_BYTES_PER_PIX, 4);
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: faces, door, zero and extreme distances, extreme fractions and rows
    for (int f = 0; f < 8; f++) send_pixel(3'(f), 0, 16'h0100, 16'hFFFF, 16'h8000, 12'(f), 10, 0);
    send_pixel(FACE_EAST, 1, 16'h0000, 16'h0000, 16'hFFFF, 12'hFFF, 20'hFFFFF, 0);
    send_pixel(3'd7, 1, 16'hFFFF, 16'hFFFF, 16'h0000, 0, 0, 0);
    send_pixel(FACE_NORTH, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 5, 0);
    send_pixel(FACE_SOUTH, 0, 16'h0001, 16'h0000, 16'h0000, 1, 20'hFFFFF, 0);
    send_pixel(FACE_WEST, 0, 16'h0100, 16'h1234, 16'hFFFF, 7, 720, 0);
    send_pixel(FACE_WEST, 0, 16'h0100, 16'h1234, 16'h0001, 8, 719, 0);
    drain();

    for (int p = 0; p < 6; p++) begin
      for (int i = 0; i < 5; i++) write_reg(reg_idx_t'(i), sets[p][i]);
      // zero wall height case under the smallest screen height
      send_pixel(FACE_NORTH, 0, 16'hFFFF, 16'($urandom()), 0, 3, 4, 0);
      for (int n = 0; n < 78; n++) random_pixel(n % 30 < 10);
      if (p == 2) begin
        // stall the output long enough to back up the input
        hold_off = 1;
        fork
          begin repeat (300) @(posedge clk); hold_off = 0; end
          for (int n = 0; n < 60; n++) random_pixel(1);
        join
      end
      drain();
    end
    // unknown index is ignored
    write_reg(reg_idx_t'(3'd6), 14'h3FFF);
    write_reg(reg_idx_t'(3'd7), 14'h0001);
    for (int n = 0; n < 10; n++) random_pixel(0);
    drain();
    if (board.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

  initial begin
    #4ms;
    $display("tb: failure");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/wctm_pkg.sv
rtl/wctm_front.sv
rtl/wctm_hdiv.sv
rtl/wctm_rdiv.sv
rtl/wctm_out.sv
rtl/wall_column_texel_mapper.sv
rtl/wctm_checker.sv
dv/testbench.sv
